// ----- rtl/agc_pkg.sv -----
// Shared types, constants and commands for the complex AGC block.
package agc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int RATE_W     = 16;
  localparam int REF_W      = 15;
  localparam int STRIDE_W   = 5;
  localparam int MAX_STRIDE = 16;
  localparam int WIN_MAX    = 4 * MAX_STRIDE;
  localparam int ADDR_W     = $clog2(WIN_MAX);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int POS_W      = $clog2(MAX_STRIDE);
  localparam int MAG_W      = 16;
  localparam int SUM_W      = 23;
  localparam int NUM_W      = 48;
  localparam int PROD_W     = 43;
  localparam int ITER_W     = 6;
  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = NUM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAXG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd4;

  typedef struct packed {
    logic [RATE_W-1:0]   attack;
    logic [RATE_W-1:0]   decay;
    logic [REF_W-1:0]    ref_level;
    logic [GAIN_W-1:0]   gain_cap;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_CAPTURE, DP_SQ_I, DP_SQ_Q, DP_SQ_SUM, DP_SQRT_STEP,
    DP_INIT_ACC, DP_MUL_REFN, DP_DIV_LD_INIT, DP_DIV_STEP, DP_GAIN_INIT,
    DP_LD_RAM, DP_MUL_GM, DP_SEL_RATE, DP_ZERO_SEL, DP_MUL_REFR,
    DP_DIV_LD_UPD, DP_MUL_GR, DP_GAIN_UPD, DP_SC_I, DP_SC_Q, DP_SAT_Q, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             last;
    logic [CNT_W-1:0] n;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic mag_zero;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_I, S_SQ_Q, S_SQ_SUM, S_SQRT, S_INIT_ACC, S_INIT_MUL,
    S_INIT_DIVLD, S_DIV, S_INIT_GAIN, S_FL_RD, S_FL_LD, S_UPD_GM, S_UPD_SEL,
    S_UPD_MR, S_UPD_DIVLD, S_UPD_MG, S_UPD_GAIN, S_SC_I, S_SC_Q, S_SC_SAT, S_EMIT
  } state_t;

  function automatic logic [POS_W:0] eff_stride(input logic [STRIDE_W-1:0] s);
    if (s == '0) return (POS_W+1)'(1);
    if (s > STRIDE_W'(MAX_STRIDE)) return (POS_W+1)'(MAX_STRIDE);
    return (POS_W+1)'(s);
  endfunction

endpackage

// ----- rtl/agc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module agc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/agc_dp.sv -----
// Datapath of the AGC: shared multiplier, iterative square root and divider, gain and output.
module agc_dp import agc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic signed [SAMPLE_W-1:0] in_i,
  input  logic signed [SAMPLE_W-1:0] in_q,
  input  logic [2*SAMPLE_W-1:0]      ram_rdata,
  output logic [2*SAMPLE_W-1:0]      ram_wdata,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_i,
  output logic signed [SAMPLE_W-1:0] out_q,
  output logic                       out_last
);
  logic signed [SAMPLE_W-1:0] si_r, sq_r, oi_r, oq_r;
  logic signed [PROD_W-1:0]   p_r, p_nxt;
  logic [31:0]                x_r;
  logic [17:0]                rem_r;
  logic [MAG_W-1:0]           root_r;
  logic [SUM_W-1:0]           sum_r;
  logic [NUM_W-1:0]           num_r;
  logic [SUM_W:0]             drem_r;
  logic [SUM_W-1:0]           den_r;
  logic [RATE_W-1:0]          r_r;
  logic [GAIN_W-1:0]          gain_r;
  logic                       ov_r, last_r;

  logic signed [24:0]         ma;
  logic signed [17:0]         mb;
  logic [19:0]                sq_rem;
  logic [19:0]                sq_trial;
  logic [SUM_W+1:0]           dv_rem;
  logic [48:0]                upd_t;
  logic [GAIN_W-1:0]          init_g;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [PROD_W-17:0]  shr;
  logic signed [SAMPLE_W-1:0] sat_v;
  logic                       refs_gt;

  // Multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      DP_SQ_I:     begin ma = 25'(si_r); mb = 18'(si_r); end
      DP_SQ_Q:     begin ma = 25'(sq_r); mb = 18'(sq_r); end
      DP_MUL_REFN: begin ma = 25'({1'b0, cfg.ref_level}); mb = 18'({1'b0, cmd.n}); end
      DP_MUL_GM:   begin ma = {1'b0, gain_r}; mb = {2'b0, root_r}; end
      DP_MUL_REFR: begin ma = 25'({1'b0, cfg.ref_level}); mb = {2'b0, r_r}; end
      DP_MUL_GR:   begin ma = {1'b0, gain_r}; mb = {1'b0, 17'(18'h10000 - {2'b0, r_r})}; end
      DP_SC_I:     begin ma = {1'b0, gain_r}; mb = 18'(si_r); end
      DP_SC_Q:     begin ma = {1'b0, gain_r}; mb = 18'(sq_r); end
      default:     begin ma = '0; mb = '0; end
    endcase
    p_nxt = PROD_W'(ma * mb);
  end

  assign sq_rem   = {rem_r, x_r[31:30]};
  assign sq_trial = {2'b0, root_r, 2'b01};
  assign dv_rem   = {drem_r, num_r[NUM_W-1]};
  assign refs_gt  = {12'b0, cfg.ref_level, 16'b0} > p_r;
  assign upd_t    = {8'b0, p_r[40:0]} + {1'b0, num_r};

  always_comb begin
    if (stat.sum_zero || num_r[NUM_W-1:GAIN_W] != '0) begin
      init_g = '1;
    end else begin
      init_g = num_r[GAIN_W-1:0];
    end
    if (cfg.gain_cap != '0 && init_g > cfg.gain_cap) begin
      init_g = cfg.gain_cap;
    end
  end

  // Round half up, then saturate to the sample width
  always_comb begin
    rnd = p_r + PROD_W'(1 << (FRAC_W - 1));
    shr = rnd[PROD_W-1:FRAC_W];
    if (shr > (PROD_W-16)'(32767)) begin
      sat_v = 16'sh7fff;
    end else if (shr < -(PROD_W-16)'(32768)) begin
      sat_v = 16'sh8000;
    end else begin
      sat_v = shr[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      sum_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= (cmd.op == DP_EMIT) || (ov_r && !out_ready);
      case (cmd.op)
        DP_INIT_ACC:  sum_r  <= sum_r + SUM_W'(root_r);
        DP_GAIN_INIT: begin gain_r <= init_g; sum_r <= '0; end
        DP_GAIN_UPD:  gain_r <= (upd_t[48:40] != '0) ? '1 : upd_t[39:16];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    case (cmd.op)
      DP_CAPTURE: begin si_r <= in_i; sq_r <= in_q; end
      DP_LD_RAM:  begin
        si_r <= ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
        sq_r <= ram_rdata[SAMPLE_W-1:0];
      end
      DP_SQ_Q:    x_r <= p_r[31:0];
      DP_SQ_SUM:  begin x_r <= x_r + p_r[31:0]; rem_r <= '0; root_r <= '0; end
      DP_SQRT_STEP: begin
        x_r <= {x_r[29:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          rem_r  <= 18'(sq_rem - sq_trial);
          root_r <= {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r  <= sq_rem[17:0];
          root_r <= {root_r[MAG_W-2:0], 1'b0};
        end
      end
      DP_DIV_LD_INIT: begin
        num_r  <= {10'b0, p_r[21:0], 16'b0};
        den_r  <= sum_r;
        drem_r <= '0;
      end
      DP_DIV_LD_UPD: begin
        num_r  <= {1'b0, p_r[30:0], 16'b0};
        den_r  <= SUM_W'(root_r);
        drem_r <= '0;
      end
      DP_DIV_STEP: begin
        if (dv_rem >= {2'b0, den_r}) begin
          drem_r <= (SUM_W+1)'(dv_rem - {2'b0, den_r});
          num_r  <= {num_r[NUM_W-2:0], 1'b1};
        end else begin
          drem_r <= dv_rem[SUM_W:0];
          num_r  <= {num_r[NUM_W-2:0], 1'b0};
        end
      end
      DP_SEL_RATE: r_r <= refs_gt ? cfg.decay : cfg.attack;
      DP_ZERO_SEL: begin r_r <= cfg.decay; num_r <= '0; end
      DP_SC_Q:     oi_r <= sat_v;
      DP_SAT_Q:    oq_r <= sat_v;
      DP_EMIT:     begin out_i <= oi_r; out_q <= oq_r; last_r <= cmd.last; end
      default: ;
    endcase
  end

  assign stat.sum_zero = (sum_r == '0);
  assign stat.mag_zero = (root_r == '0);
  assign stat.out_busy = ov_r && !out_ready;
  assign out_valid     = ov_r;
  assign out_last      = last_r;
  assign ram_wdata     = {si_r, sq_r};

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_EMIT |-> !stat.out_busy)
    else $error("result loaded over an untaken one");
  a_gain_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_GAIN_INIT |=> (cfg.gain_cap == '0 || gain_r <= cfg.gain_cap))
    else $error("initial gain above limit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(out_i) && $stable(out_q) && $stable(last_r)))
    else $error("stalled result changed");
endmodule

// ----- rtl/agc_ctrl.sv -----
// Control state machine of the AGC: sequences collection, gain updates and result transfers.
module agc_ctrl import agc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [ADDR_W-1:0] ram_raddr
);
  state_t             state_r, state_nxt;
  logic               pend_r, pend_nxt;
  logic               fl_r, fl_nxt;
  logic               upd_r, upd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  k_r, k_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ITER_W-1:0]  it_r, it_nxt;
  logic [POS_W:0]     stride;
  logic [POS_W:0]     pos_eff;
  logic               k_last;

  assign stride  = eff_stride(cfg.stride);
  assign pos_eff = ({1'b0, pos_r} >= stride) ? '0 : {1'b0, pos_r};
  assign k_last  = ({1'b0, k_r} + CNT_W'(1)) == cnt_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    fl_nxt    = fl_r;
    upd_nxt   = upd_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    it_nxt    = it_r - ITER_W'(1);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (pend_r) begin
            state_nxt = S_SQ_I;
          end else begin
            upd_nxt   = (pos_eff == '0);
            pos_nxt   = ((pos_eff + 1'b1) >= stride) ? '0 : POS_W'(pos_eff + 1'b1);
            state_nxt = (pos_eff == '0) ? S_SQ_I : S_SC_I;
          end
        end
      end
      S_SQ_I:   state_nxt = S_SQ_Q;
      S_SQ_Q:   state_nxt = S_SQ_SUM;
      S_SQ_SUM: begin state_nxt = S_SQRT; it_nxt = ITER_W'(SQRT_STEPS - 1); end
      S_SQRT: begin
        if (it_r == '0) begin
          state_nxt = pend_r ? S_INIT_ACC : S_UPD_GM;
        end
      end
      S_INIT_ACC: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if ((cnt_r + CNT_W'(1)) >= CNT_W'({stride, 2'b00})) begin
          state_nxt = S_INIT_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INIT_MUL: state_nxt = S_INIT_DIVLD;
      S_INIT_DIVLD: begin
        it_nxt    = ITER_W'(DIV_STEPS - 1);
        state_nxt = stat.sum_zero ? S_INIT_GAIN : S_DIV;
      end
      S_DIV: begin
        if (it_r == '0) begin
          state_nxt = pend_r ? S_INIT_GAIN : S_UPD_MG;
        end
      end
      S_INIT_GAIN: begin
        pend_nxt  = 1'b0;
        fl_nxt    = 1'b1;
        pos_nxt   = '0;
        k_nxt     = '0;
        state_nxt = S_FL_RD;
      end
      S_FL_RD:   state_nxt = S_FL_LD;
      S_FL_LD:   state_nxt = S_SC_I;
      S_UPD_GM:  state_nxt = S_UPD_SEL;
      S_UPD_SEL: state_nxt = stat.mag_zero ? S_UPD_MG : S_UPD_MR;
      S_UPD_MR:  state_nxt = S_UPD_DIVLD;
      S_UPD_DIVLD: begin state_nxt = S_DIV; it_nxt = ITER_W'(DIV_STEPS - 1); end
      S_UPD_MG:   state_nxt = S_UPD_GAIN;
      S_UPD_GAIN: state_nxt = S_SC_I;
      S_SC_I:     state_nxt = S_SC_Q;
      S_SC_Q:     state_nxt = S_SC_SAT;
      S_SC_SAT:   state_nxt = S_EMIT;
      S_EMIT: begin
        if (!stat.out_busy) begin
          if (fl_r && !k_last) begin
            k_nxt     = k_r + ADDR_W'(1);
            state_nxt = S_FL_RD;
          end else begin
            fl_nxt    = 1'b0;
            if (fl_r) begin
              cnt_nxt = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op    = DP_NONE;
    cmd.last  = !fl_r || k_last;
    cmd.n     = cnt_r;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[ADDR_W-1:0];
    ram_raddr = k_r;
    case (state_r)
      S_IDLE:       begin in_ready = 1'b1; if (in_valid) cmd.op = DP_CAPTURE; end
      S_SQ_I:       cmd.op = DP_SQ_I;
      S_SQ_Q:       cmd.op = DP_SQ_Q;
      S_SQ_SUM:     cmd.op = DP_SQ_SUM;
      S_SQRT:       cmd.op = DP_SQRT_STEP;
      S_INIT_ACC:   begin cmd.op = DP_INIT_ACC; ram_we = 1'b1; end
      S_INIT_MUL:   cmd.op = DP_MUL_REFN;
      S_INIT_DIVLD: cmd.op = DP_DIV_LD_INIT;
      S_DIV:        cmd.op = DP_DIV_STEP;
      S_INIT_GAIN:  cmd.op = DP_GAIN_INIT;
      S_FL_LD:      cmd.op = DP_LD_RAM;
      S_UPD_GM:     cmd.op = DP_MUL_GM;
      S_UPD_SEL:    cmd.op = stat.mag_zero ? DP_ZERO_SEL : DP_SEL_RATE;
      S_UPD_MR:     cmd.op = DP_MUL_REFR;
      S_UPD_DIVLD:  cmd.op = DP_DIV_LD_UPD;
      S_UPD_MG:     cmd.op = DP_MUL_GR;
      S_UPD_GAIN:   cmd.op = DP_GAIN_UPD;
      S_SC_I:       cmd.op = DP_SC_I;
      S_SC_Q:       cmd.op = DP_SC_Q;
      S_SC_SAT:     cmd.op = DP_SAT_Q;
      S_EMIT:       if (!stat.out_busy) cmd.op = DP_EMIT;
      default:      cmd.op = DP_NONE;
    endcase
    if (state_r == S_SC_I && !upd_r && !fl_r) begin
      cmd.op = DP_SC_I;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b1;
      fl_r    <= 1'b0;
      upd_r   <= 1'b0;
      cnt_r   <= '0;
      k_r     <= '0;
      pos_r   <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      fl_r    <= fl_nxt;
      upd_r   <= upd_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
      it_r    <= it_nxt;
    end
  end

  a_we_collect: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> pend_r && !fl_r)
    else $error("buffer written outside collection");
  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fl_r |-> ({1'b0, k_r} < cnt_r))
    else $error("flush index past window");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> state_r != S_IDLE)
    else $error("transfer did not start work");
endmodule

// ----- rtl/complex_agc_decimated_update.sv -----
// Top level of the complex AGC with decimated attack/decay gain update.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid/in_ready, in_sample_i/q        | in
//  result  | out_valid/out_ready, out_i/q, last_of_run | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data | in
//
// One item at a time. A sample without a gain update passes from its transfer
// to the result load through capture, two multiplies, saturation and load. A
// gain update adds squaring, a 16-step square root, setup, a 48-step restoring
// divide and a blend; a zero magnitude skips the divide. A collecting sample
// is squared, rooted, summed and stored; the window-completing one adds the
// initial gain divide (skipped on a zero sum), then reads, loads and scales
// each stored sample. Reset is synchronous, active low; the buffer needs no
// clearing. A stalled result holds in the output register while the block
// returns to accept the next sample; the next load waits until it transfers.
module complex_agc_decimated_update import agc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic signed [SAMPLE_W-1:0] in_sample_q,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_i,
  output logic signed [SAMPLE_W-1:0] out_q,
  output logic                       out_last_of_run,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);
  cfg_t               cfg_r;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [2*SAMPLE_W-1:0] ram_wdata, ram_rdata;

  // Configuration registers: always ready, drop writes to unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack    <= RATE_W'(655);
      cfg_r.decay     <= RATE_W'(66);
      cfg_r.ref_level <= REF_W'(16384);
      cfg_r.gain_cap  <= '0;
      cfg_r.stride    <= STRIDE_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTACK: cfg_r.attack    <= cfg_data[RATE_W-1:0];
        REG_DECAY:  cfg_r.decay     <= cfg_data[RATE_W-1:0];
        REG_REF:    cfg_r.ref_level <= cfg_data[REF_W-1:0];
        REG_MAXG:   cfg_r.gain_cap  <= cfg_data[GAIN_W-1:0];
        REG_STRIDE: cfg_r.stride    <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  agc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr)
  );

  agc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .stat      (stat),
    .in_i      (in_sample_i),
    .in_q      (in_sample_q),
    .ram_rdata (ram_rdata),
    .ram_wdata (ram_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_i     (out_i),
    .out_q     (out_q),
    .out_last  (out_last_of_run)
  );

  // Window buffer for the first samples after reset
  agc_ram #(.WIDTH(2 * SAMPLE_W), .DEPTH(WIN_MAX)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule

// ----- bench/complex_agc_decimated_update_test.sv -----
// Self-checking testbench for the complex AGC with decimated gain update.
module complex_agc_decimated_update_test import agc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
    logic                       last;
  } agc_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_i;
  logic signed [SAMPLE_W-1:0] in_sample_q;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_i;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       out_last_of_run;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  complex_agc_decimated_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_i(in_sample_i), .in_sample_q(in_sample_q),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_i(out_i), .out_q(out_q), .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the gain state.
  logic [RATE_W-1:0]   pr_attack;
  logic [RATE_W-1:0]   pr_decay;
  logic [REF_W-1:0]    pr_ref;
  logic [GAIN_W-1:0]   pr_gain_cap;
  logic [STRIDE_W-1:0] pr_stride;
  logic [GAIN_W-1:0]   pr_gain;
  bit                  pr_collecting;
  int unsigned         pr_count;
  longint unsigned     pr_mag_sum;
  logic signed [SAMPLE_W-1:0] pr_win_i [WIN_MAX];
  logic signed [SAMPLE_W-1:0] pr_win_q [WIN_MAX];
  int unsigned         pr_pos;

  agc_result_t expected_q[$];
  int          error_count;
  int          cycle_count;
  bit          rx_stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("complex_agc_decimated_update test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_of(input logic signed [SAMPLE_W-1:0] i,
                                              input logic signed [SAMPLE_W-1:0] q);
    longint si, sq;
    si = i;
    sq = q;
    return int_sqrt(longint'(si * si) + longint'(sq * sq));
  endfunction

  // Multiply by Q8.16 gain, round half up, saturate to the sample width.
  function automatic logic signed [SAMPLE_W-1:0] apply_gain(input logic signed [SAMPLE_W-1:0] x,
                                                              input logic [GAIN_W-1:0] g);
    longint p, r;
    p = longint'(x) * longint'({40'd0, g}) + (64'sd1 <<< (FRAC_W - 1));
    r = p >>> FRAC_W;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic int unsigned stride_now();
    if (pr_stride == 0) return 1;
    if (pr_stride > MAX_STRIDE) return MAX_STRIDE;
    return pr_stride;
  endfunction

  task automatic predict_gain(input logic signed [SAMPLE_W-1:0] si,
                              input logic signed [SAMPLE_W-1:0] sq);
    int unsigned st, n, slot, k;
    longint unsigned g, m, refs, r, t;
    agc_result_t res;
    st = stride_now();
    if (pr_collecting) begin
      slot = pr_count % WIN_MAX;
      pr_win_i[slot] = si;
      pr_win_q[slot] = sq;
      pr_mag_sum += mag_of(si, sq);
      pr_count = slot + 1;
      if (pr_count < 4 * st) return;
      n = pr_count;
      if (pr_mag_sum == 0) g = 24'hFFFFFF;
      else begin
        g = ((longint'(pr_ref) * n) << FRAC_W) / pr_mag_sum;
        if (g > 24'hFFFFFF) g = 24'hFFFFFF;
      end
      if (pr_gain_cap != 0 && g > pr_gain_cap) g = pr_gain_cap;
      pr_gain = GAIN_W'(g);
      for (k = 0; k < n; k++) begin
        res.i = apply_gain(pr_win_i[k], pr_gain);
        res.q = apply_gain(pr_win_q[k], pr_gain);
        res.last = (k + 1 == n);
        expected_q.push_back(res);
      end
      pr_collecting = 0;
      pr_count = 0;
      pr_mag_sum = 0;
      pr_pos = 0;
      return;
    end
    if (pr_pos >= st) pr_pos = 0;
    if (pr_pos == 0) begin
      m = mag_of(si, sq);
      g = pr_gain;
      if (m != 0) begin
        refs = longint'(pr_ref) << FRAC_W;
        r = (refs > g * m) ? pr_decay : pr_attack;
        t = (g * ((64'd1 << RATE_W) - r) + (refs * r) / m) >> RATE_W;
        pr_gain = GAIN_W'((t > 24'hFFFFFF) ? 24'hFFFFFF : t);
      end else begin
        pr_gain = GAIN_W'((g * ((64'd1 << RATE_W) - pr_decay)) >> RATE_W);
      end
    end
    pr_pos = (pr_pos + 1 >= st) ? 0 : pr_pos + 1;
    res.i = apply_gain(si, pr_gain);
    res.q = apply_gain(sq, pr_gain);
    res.last = 1'b1;
    expected_q.push_back(res);
  endtask

  // Result checker with its own stall pattern: long ready runs alternate
  // with stretches of random stalls.
  always @(posedge clk) begin
    agc_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer, out_i", out_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_i !== want.i) report_mismatch("out_i", out_i, want.i);
          if (out_q !== want.q) report_mismatch("out_q", out_q, want.q);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
        end
      end
      if ($urandom_range(0, 63) == 0) rx_stall_on <= ~rx_stall_on;
      out_ready <= rx_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Drop valid after the transfer and hold it low so the next item
  // starts on a fresh edge.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                             input logic signed [SAMPLE_W-1:0] sq);
    in_valid    <= 1'b1;
    in_sample_i <= si;
    in_sample_q <= sq;
    do @(posedge clk); while (!in_ready);
    predict_gain(si, sq);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Burst sender: random burst length, random gap between bursts.
  int burst_left;
  task automatic paced_sample(input logic signed [SAMPLE_W-1:0] si,
                              input logic signed [SAMPLE_W-1:0] sq);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    send_sample(si, sq);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ATTACK: pr_attack   = val[RATE_W-1:0];
      REG_DECAY:  pr_decay    = val[RATE_W-1:0];
      REG_REF:    pr_ref      = val[REF_W-1:0];
      REG_MAXG:   pr_gain_cap = val[GAIN_W-1:0];
      REG_STRIDE: pr_stride   = val[STRIDE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drain pending results, then let the last update finish before a write.
  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return SAMPLE_W'($urandom_range(0, 15) - 8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Window fill plus a run of updates at the default registers.
  task automatic test_directed_extremes();
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh0001, 16'shFFFF);
    // Updates: zero magnitude shrink, full-scale attack, tiny decay.
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sh8000);
    send_sample(16'sh5555, 16'shAAAA);
    wait_idle();
  endtask

  // Re-arm collection by reset is not allowed, so check the zero-magnitude and
  // clamp cases only through the update path at extreme registers.
  task automatic test_register_extremes();
    write_reg(REG_ATTACK, 24'd65535);
    write_reg(REG_DECAY, 24'd65535);
    write_reg(REG_REF, 24'd32767);
    write_reg(REG_MAXG, 24'hFFFFFF);
    write_reg(REG_STRIDE, 24'd0);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd1);
    send_sample(16'sh7FFF, 16'sd0);
    send_sample(16'sd3, 16'sd4);
    wait_idle();
    write_reg(REG_ATTACK, 24'd1);
    write_reg(REG_DECAY, 24'd1);
    write_reg(REG_REF, 24'd1);
    write_reg(REG_MAXG, 24'd0);
    write_reg(REG_STRIDE, 24'd31);
    repeat (6) send_sample(rand_sample(), rand_sample());
    // Lower the stride below the group position.
    wait_idle();
    write_reg(REG_STRIDE, 24'd2);
    repeat (4) send_sample(rand_sample(), rand_sample());
    wait_idle();
  endtask

  task automatic test_random_phases();
    int phase, k;
    for (phase = 0; phase < 8; phase++) begin
      write_reg(REG_ATTACK,
                CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 65535) : 655));
      write_reg(REG_DECAY,
                CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 65535) : 66));
      write_reg(REG_REF, CFG_DATA_W'($urandom_range(1, 32767)));
      write_reg(REG_MAXG, CFG_DATA_W'($urandom_range(0, 1) ? 0 : $urandom()));
      write_reg(REG_STRIDE, CFG_DATA_W'((phase == 7) ? 16 : $urandom_range(0, 31)));
      for (k = 0; k < 48; k++) paced_sample(rand_sample(), rand_sample());
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_i = '0;
    in_sample_q = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ATTACK;
    cfg_data = '0;
    rx_stall_on = 1'b0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    pr_attack = RATE_W'(655);
    pr_decay = RATE_W'(66);
    pr_ref = REF_W'(16384);
    pr_gain_cap = '0;
    pr_stride = STRIDE_W'(1);
    pr_gain = '0;
    pr_collecting = 1;
    pr_count = 0;
    pr_mag_sum = 0;
    pr_pos = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_register_extremes();
    test_random_phases();
    if (error_count == 0) begin
      $display("complex_agc_decimated_update test passed");
    end else begin
      $display("complex_agc_decimated_update test failed");
    end
    $finish;
  end

endmodule
